/* hw/rtl/stream_substring_replace_unit_defines.svh */
// ----------------------------------------------------------------------------
// stream substring replace unit assertion macros
// shared property shapes for the checker of the replace unit
// ----------------------------------------------------------------------------
`ifndef STREAM_SUBSTRING_REPLACE_UNIT_DEFINES_SVH
`define STREAM_SUBSTRING_REPLACE_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define SSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ssr_pkg.sv */
// ----------------------------------------------------------------------------
// ssr_pkg
// types, register indexes and sizes shared by the replace unit modules
// ----------------------------------------------------------------------------
package ssr_pkg;

	localparam int PATTERN_MAX_DEF     = 8;
	localparam int REPLACEMENT_MAX_DEF = 8;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 4;
	localparam int CFG_BYTES  = 8;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 4'd3;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] pattern_bytes;
		logic [LEN_W-1:0]      pattern_length;
		logic [CFG_DATA_W-1:0] replacement_bytes;
		logic [LEN_W-1:0]      replacement_length;
	} cfg_t;

	// what the back end has to do for one command
	typedef struct packed {
		logic repl;
		logic eot;
	} cmd_ctl_t;

endpackage

/* hw/rtl/ssr_in_if.sv */
// ----------------------------------------------------------------------------
// ssr_in_if
// text byte channel into the replace unit
// ----------------------------------------------------------------------------
interface ssr_in_if;
	import ssr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_char;
	logic              end_of_text;

	modport source (output valid, output text_char, output end_of_text, input ready);
	modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

/* hw/rtl/ssr_out_if.sv */
// ----------------------------------------------------------------------------
// ssr_out_if
// rewritten text channel out of the replace unit
// ----------------------------------------------------------------------------
interface ssr_out_if;
	import ssr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_char;
	logic              has_char;
	logic              last;

	modport source (output valid, output out_char, output has_char, output last, input ready);
	modport sink (input valid, input out_char, input has_char, input last, output ready);
endinterface

/* hw/rtl/ssr_cfg_if.sv */
// ----------------------------------------------------------------------------
// ssr_cfg_if
// register write channel of the replace unit
// ----------------------------------------------------------------------------
interface ssr_cfg_if;
	import ssr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/ssr_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// ssr_cmd_fifo
// short command queue between the window front end and the output sequencer
// ----------------------------------------------------------------------------
module ssr_cmd_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);
	import ssr_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

/* hw/rtl/ssr_front.sv */
// ----------------------------------------------------------------------------
// ssr_front
// takes text bytes, keeps the pending window, matches it against the pattern
// and hands one command per emitting byte to the queue
// ----------------------------------------------------------------------------
module ssr_front #(
	parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	ssr_in_if.sink                               text,
	input  ssr_pkg::cfg_t                        cfg_regs,
	input  logic                                 win_clear,
	input  logic                                 q_full,
	output logic                                 cmd_push,
	output ssr_pkg::cmd_ctl_t                    cmd_ctl,
	output logic [PATTERN_MAX*ssr_pkg::BYTE_W-1:0] cmd_bytes,
	output logic [$clog2(PATTERN_MAX+1)-1:0]     cmd_nbytes
);
	import ssr_pkg::*;

	localparam int CNT_W = $clog2(PATTERN_MAX + 1);

	logic [BYTE_W-1:0] win_q [PATTERN_MAX];
	logic [CNT_W-1:0]  fill_q;
	logic [BYTE_W-1:0] nw [PATTERN_MAX];
	logic [BYTE_W-1:0] pat [PATTERN_MAX];
	logic [LEN_W:0]    plen_wide;
	logic [CNT_W-1:0]  plen;
	logic [CNT_W-1:0]  fill_inc;
	logic [CNT_W-1:0]  fill_nx;
	logic              full;
	logic              match;
	logic              accept;
	logic              eot;

	assign text.ready = !q_full;
	assign accept     = text.valid && text.ready;
	assign eot        = text.end_of_text;

	// pattern bytes past the register compare as zero
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pat
		if (k < CFG_BYTES) begin : g_reg
			assign pat[k] = cfg_regs.pattern_bytes[BYTE_W*k +: BYTE_W];
		end else begin : g_zero
			assign pat[k] = '0;
		end
	end

	// length zero acts as one, long lengths clamp to the window size
	always_comb begin
		plen_wide = {1'b0, cfg_regs.pattern_length};
		if (plen_wide == '0) begin
			plen_wide = (LEN_W + 1)'(1);
		end
		if (plen_wide > (LEN_W + 1)'(PATTERN_MAX)) begin
			plen_wide = (LEN_W + 1)'(PATTERN_MAX);
		end
		plen = CNT_W'(plen_wide);
	end

	assign fill_inc = fill_q + 1'b1;
	assign full     = (fill_inc == plen);

	always_comb begin
		match = 1'b1;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			nw[k] = (CNT_W'(k) == fill_q) ? text.text_char : win_q[k];
		end
		for (int k = 0; k < PATTERN_MAX; k++) begin
			if ((CNT_W'(k) < plen) && (nw[k] != pat[k])) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		cmd_ctl.eot  = eot;
		cmd_ctl.repl = 1'b0;
		cmd_nbytes   = '0;
		fill_nx      = fill_inc;
		if (full && match) begin
			cmd_ctl.repl = 1'b1;
			fill_nx      = '0;
		end else if (full) begin
			// oldest byte leaves; at end of text the whole window goes out
			cmd_nbytes = eot ? plen : CNT_W'(1);
			fill_nx    = eot ? '0 : plen - 1'b1;
		end else begin
			cmd_nbytes = eot ? fill_inc : '0;
			fill_nx    = eot ? '0 : fill_inc;
		end
		for (int k = 0; k < PATTERN_MAX; k++) begin
			cmd_bytes[BYTE_W*k +: BYTE_W] = nw[k];
		end
	end

	assign cmd_push = accept && (full || eot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (win_clear) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (full && !match) begin
				for (int k = 0; k < PATTERN_MAX - 1; k++) begin
					win_q[k] <= nw[k+1];
				end
				win_q[PATTERN_MAX-1] <= '0;
			end else begin
				for (int k = 0; k < PATTERN_MAX; k++) begin
					win_q[k] <= nw[k];
				end
			end
		end
	end
endmodule

/* hw/rtl/ssr_back.sv */
// ----------------------------------------------------------------------------
// ssr_back
// output sequencer: plays out replacement and window bytes of each command
// through a registered output stage
// ----------------------------------------------------------------------------
module ssr_back #(
	parameter int PATTERN_MAX     = ssr_pkg::PATTERN_MAX_DEF,
	parameter int REPLACEMENT_MAX = ssr_pkg::REPLACEMENT_MAX_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ssr_pkg::cfg_t                        cfg_regs,
	input  logic                                 q_empty,
	output logic                                 q_pop,
	input  ssr_pkg::cmd_ctl_t                    cmd_ctl,
	input  logic [PATTERN_MAX*ssr_pkg::BYTE_W-1:0] cmd_bytes,
	input  logic [$clog2(PATTERN_MAX+1)-1:0]     cmd_nbytes,
	ssr_out_if.source                            result
);
	import ssr_pkg::*;

	localparam int CNT_W  = $clog2(PATTERN_MAX + 1);
	localparam int RCNT_W = $clog2(REPLACEMENT_MAX + 1);

	logic              busy_q;
	logic [RCNT_W-1:0] rem_repl_q;
	logic [CNT_W-1:0]  rem_win_q;
	logic              eot_q;
	logic [BYTE_W-1:0] repl_q [REPLACEMENT_MAX];
	logic [BYTE_W-1:0] win_q [PATTERN_MAX];
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_char_q;
	logic              has_char_q;
	logic              last_q;

	logic [BYTE_W-1:0] rb [REPLACEMENT_MAX];
	logic [LEN_W:0]    rlen_wide;
	logic [RCNT_W-1:0] rlen;
	logic              slot_free;
	logic              step;
	logic              emit;
	logic              done;
	logic [BYTE_W-1:0] e_char;
	logic              e_has;
	logic              e_last;

	// replacement bytes past the register emit as zero
	for (genvar k = 0; k < REPLACEMENT_MAX; k++) begin : g_rb
		if (k < CFG_BYTES) begin : g_reg
			assign rb[k] = cfg_regs.replacement_bytes[BYTE_W*k +: BYTE_W];
		end else begin : g_zero
			assign rb[k] = '0;
		end
	end

	always_comb begin
		rlen_wide = {1'b0, cfg_regs.replacement_length};
		if (rlen_wide > (LEN_W + 1)'(REPLACEMENT_MAX)) begin
			rlen_wide = (LEN_W + 1)'(REPLACEMENT_MAX);
		end
		rlen = RCNT_W'(rlen_wide);
	end

	assign q_pop     = !busy_q && !q_empty;
	assign slot_free = !out_valid_q || result.ready;
	assign step      = busy_q && slot_free;

	always_comb begin
		emit   = 1'b0;
		done   = 1'b0;
		e_char = '0;
		e_has  = 1'b0;
		e_last = 1'b0;
		if (rem_repl_q != '0) begin
			emit   = 1'b1;
			e_char = repl_q[0];
			e_has  = 1'b1;
			done   = (rem_repl_q == RCNT_W'(1)) && (rem_win_q == '0);
			e_last = eot_q && done;
		end else if (rem_win_q != '0) begin
			emit   = 1'b1;
			e_char = win_q[0];
			e_has  = 1'b1;
			done   = (rem_win_q == CNT_W'(1));
			e_last = eot_q && done;
		end else begin
			// empty end marker when the last byte caused nothing else
			emit   = eot_q;
			e_last = 1'b1;
			done   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rem_repl_q  <= '0;
			rem_win_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q     <= 1'b1;
				rem_repl_q <= cmd_ctl.repl ? rlen : '0;
				rem_win_q  <= cmd_nbytes;
			end else if (step) begin
				if (done) begin
					busy_q <= 1'b0;
				end
				if (rem_repl_q != '0) begin
					rem_repl_q <= rem_repl_q - 1'b1;
				end else if (rem_win_q != '0) begin
					rem_win_q <= rem_win_q - 1'b1;
				end
			end
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (step && emit) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			eot_q <= cmd_ctl.eot;
			for (int k = 0; k < REPLACEMENT_MAX; k++) begin
				repl_q[k] <= rb[k];
			end
			for (int k = 0; k < PATTERN_MAX; k++) begin
				win_q[k] <= cmd_bytes[BYTE_W*k +: BYTE_W];
			end
		end else if (step) begin
			if (rem_repl_q != '0) begin
				for (int k = 0; k < REPLACEMENT_MAX - 1; k++) begin
					repl_q[k] <= repl_q[k+1];
				end
				repl_q[REPLACEMENT_MAX-1] <= '0;
			end else if (rem_win_q != '0) begin
				for (int k = 0; k < PATTERN_MAX - 1; k++) begin
					win_q[k] <= win_q[k+1];
				end
				win_q[PATTERN_MAX-1] <= '0;
			end
		end
		if (step && emit) begin
			out_char_q <= e_char;
			has_char_q <= e_has;
			last_q     <= e_last;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.out_char = out_char_q;
	assign result.has_char = has_char_q;
	assign result.last     = last_q;
endmodule

/* hw/rtl/stream_substring_replace_unit.sv */
// ----------------------------------------------------------------------------
// stream_substring_replace_unit
// streaming find and replace of a configured pattern in a byte stream
// ----------------------------------------------------------------------------
//  channel  dir  transfer carries
//  text     in   text_char, end_of_text
//  result   out  out_char, has_char, last
//  cfg      in   index, data (register write, always ready)
//
//  a text byte is taken whenever the command queue has room
//  the back end loads one command at a time, then plays out its results while the output stage has room:
//  the replacement bytes on a match, one byte on a non-matching full window,
//  plus the flushed window bytes at end of text; this sequencer sets the rate
//  reset clears the window fill, the queue, the sequencer and output valid,
//  and returns the registers to pattern 0 length 1, replacement 0 length 1
// ----------------------------------------------------------------------------
module stream_substring_replace_unit #(
	parameter int PATTERN_MAX     = ssr_pkg::PATTERN_MAX_DEF,
	parameter int REPLACEMENT_MAX = ssr_pkg::REPLACEMENT_MAX_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ssr_in_if.sink    text,
	ssr_out_if.source result,
	ssr_cfg_if.sink   cfg
);
	import ssr_pkg::*;

	localparam int CNT_W = $clog2(PATTERN_MAX + 1);
	localparam int CMD_W = $bits(cmd_ctl_t) + CNT_W + PATTERN_MAX * BYTE_W;

	cfg_t                          cfg_q;
	logic                          win_clear;
	logic                          q_full;
	logic                          q_empty;
	logic                          q_pop;
	logic                          cmd_push;
	cmd_ctl_t                      push_ctl;
	logic [PATTERN_MAX*BYTE_W-1:0] push_bytes;
	logic [CNT_W-1:0]              push_nbytes;
	cmd_ctl_t                      pop_ctl;
	logic [PATTERN_MAX*BYTE_W-1:0] pop_bytes;
	logic [CNT_W-1:0]              pop_nbytes;
	logic [CMD_W-1:0]              push_word;
	logic [CMD_W-1:0]              pop_word;

	assign cfg.ready = 1'b1;

	// a new pattern drops the pending window
	assign win_clear = cfg.valid &&
		((cfg.index == REG_PATTERN_BYTES) || (cfg.index == REG_PATTERN_LENGTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_bytes      <= '0;
			cfg_q.pattern_length     <= LEN_W'(1);
			cfg_q.replacement_bytes  <= '0;
			cfg_q.replacement_length <= LEN_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PATTERN_BYTES: begin
					cfg_q.pattern_bytes <= cfg.data;
				end
				REG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg.data[LEN_W-1:0];
				end
				REG_REPLACEMENT_BYTES: begin
					cfg_q.replacement_bytes <= cfg.data;
				end
				REG_REPLACEMENT_LENGTH: begin
					cfg_q.replacement_length <= cfg.data[LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	ssr_front #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.cfg_regs   (cfg_q),
		.win_clear  (win_clear),
		.q_full     (q_full),
		.cmd_push   (cmd_push),
		.cmd_ctl    (push_ctl),
		.cmd_bytes  (push_bytes),
		.cmd_nbytes (push_nbytes)
	);

	assign push_word = {push_ctl, push_nbytes, push_bytes};
	assign {pop_ctl, pop_nbytes, pop_bytes} = pop_word;

	ssr_cmd_fifo #(
		.W (CMD_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (push_word),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_word),
		.empty     (q_empty)
	);

	ssr_back #(
		.PATTERN_MAX     (PATTERN_MAX),
		.REPLACEMENT_MAX (REPLACEMENT_MAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_regs   (cfg_q),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.cmd_ctl    (pop_ctl),
		.cmd_bytes  (pop_bytes),
		.cmd_nbytes (pop_nbytes),
		.result     (result)
	);
endmodule

/* hw/rtl/ssr_checker.sv */
// ----------------------------------------------------------------------------
// ssr_checker
// port level checks of the replace unit, bound to the top level
// ----------------------------------------------------------------------------
`include "stream_substring_replace_unit_defines.svh"

module ssr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       has_char,
	input logic       last,
	input logic       cfg_valid,
	input logic       cfg_ready
);
	// an empty result only ever closes a text and carries a zero byte
	`SSR_ASSERT_NOW(a_empty_is_end, clk, arst_n, out_valid && !has_char, last && (out_char == 8'd0), "empty result without last or with data")

	// a result held back keeps its contents
	`SSR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(has_char) && $stable(last), "stalled result changed")

	// register writes are never held off
	`SSR_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready, "register write stalled")
endmodule

bind stream_substring_replace_unit ssr_checker u_ssr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_char  (result.out_char),
	.has_char  (result.has_char),
	.last      (result.last),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);
